// File: design/rhd_pkg.sv
// Shared types and codes of the RTP H.264 depacketizer.
`default_nettype none

package rhd_pkg;

  localparam int LEN_W = 21;
  localparam int QUEUE_DEPTH = 4;

  // result status codes
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_STORED  = 3'd5;
  localparam logic [2:0] ST_READ    = 3'd6;

  // start code plus NAL header byte
  localparam logic [2:0] UNIT_OPEN_BYTES = 3'd5;

  typedef struct packed {
    logic [2:0]       status;
    logic [LEN_W-1:0] frame_length;
    logic [15:0]      sequence_number;
    logic [31:0]      rtp_timestamp;
    logic [7:0]       nal_type_byte;
  } result_t;

  // one classified item handed from the parser to the store
  typedef struct packed {
    logic             is_read;
    logic             rd_ok;
    logic [19:0]      ridx;
    logic             open;
    logic [2:0]       wr_count;
    logic [LEN_W-1:0] wr_addr;
    logic [7:0]       wr_byte;
    result_t          res;
  } job_t;

endpackage

`default_nettype wire

// File: design/rhd_front.sv
// Packet parser: header capture, NAL classification and frame bookkeeping.
`default_nettype none

module rhd_front #(
  parameter int FRAME_BYTES = 1048576
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic                     in_cmd,
  input  wire logic [7:0]               in_byte,
  input  wire logic                     in_last,
  input  wire logic [19:0]              in_ridx,
  input  wire logic                     q_ready,
  input  wire logic                     cfg_we,
  input  wire logic [rhd_pkg::LEN_W-1:0] cfg_wdata,
  output rhd_pkg::job_t                 job
);
  import rhd_pkg::*;

  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_SINGLE   = 3'd1;
  localparam logic [2:0] KIND_IGNORE   = 3'd2;
  localparam logic [2:0] KIND_FU_WAIT  = 3'd4;
  localparam logic [2:0] KIND_FU_START = 3'd5;
  localparam logic [2:0] KIND_FU_MID   = 3'd6;
  localparam logic [2:0] KIND_FU_END   = 3'd7;

  localparam logic [15:0] POS_MARK    = 16'd1;
  localparam logic [15:0] POS_SEQ_HI  = 16'd2;
  localparam logic [15:0] POS_SEQ_LO  = 16'd3;
  localparam logic [15:0] POS_TS_HI   = 16'd4;
  localparam logic [15:0] POS_TS_LO   = 16'd7;
  localparam logic [15:0] POS_HDR_END = 16'd11;
  localparam logic [15:0] POS_NAL     = 16'd12;
  localparam logic [15:0] POS_FU_HDR  = 16'd13;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;

  localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
  localparam logic [4:0] NAL_FU_A       = 5'd28;
  localparam logic [4:0] NAL_FU_B       = 5'd29;

  localparam logic [7:0] HDR_P_SLICE = 8'h61;
  localparam logic [7:0] HDR_IDR     = 8'h65;
  localparam logic [7:0] HDR_SEI     = 8'h06;

  localparam logic [LEN_W-1:0] LIM_RST =
    LEN_W'((FRAME_BYTES < 1048576) ? FRAME_BYTES : 1048576);

  logic [15:0]      pos_r, pos_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic             pmark_r, pmark_nxt;
  logic [15:0]      pseq_r, pseq_nxt;
  logic [31:0]      pts_r, pts_nxt;
  logic             mark_r, mark_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [31:0]      ts_r, ts_nxt;
  logic [7:0]       nal_r, nal_nxt;
  logic [7:0]       uhdr_r, uhdr_nxt;
  logic [LEN_W-1:0] comm_r, comm_nxt;
  logic [LEN_W-1:0] wr_r, wr_nxt;
  logic             ovf_r, ovf_nxt;
  logic             closed_r, closed_nxt;
  logic [LEN_W-1:0] lim_r;

  logic [LEN_W:0]   room;
  logic [2:0]       open_n;
  logic             put_ok;
  logic             wr_gt;
  logic             open_v;
  logic             put_v;
  logic             commit_v;
  logic             fail;
  logic [7:0]       open_hdr;
  logic [7:0]       chdr;
  logic [2:0]       status_v;
  logic             accept;

  assign accept = in_valid && q_ready;

  // bytes of a new unit that still fit below the limit
  assign room = {1'b0, lim_r} - {1'b0, comm_r};
  always_comb begin
    if (room[LEN_W] || room == '0) begin
      open_n = 3'd0;
    end else if (room >= (LEN_W+1)'(UNIT_OPEN_BYTES)) begin
      open_n = UNIT_OPEN_BYTES;
    end else begin
      open_n = room[2:0];
    end
  end

  assign put_ok = !ovf_r && (wr_r < lim_r);
  assign wr_gt  = wr_r > lim_r;

  always_comb begin
    pos_nxt    = pos_r;
    kind_nxt   = kind_r;
    pmark_nxt  = pmark_r;
    pseq_nxt   = pseq_r;
    pts_nxt    = pts_r;
    mark_nxt   = mark_r;
    seq_nxt    = seq_r;
    ts_nxt     = ts_r;
    nal_nxt    = nal_r;
    uhdr_nxt   = uhdr_r;
    comm_nxt   = comm_r;
    wr_nxt     = wr_r;
    ovf_nxt    = ovf_r;
    closed_nxt = closed_r;
    open_v     = 1'b0;
    put_v      = 1'b0;
    commit_v   = 1'b0;
    fail       = 1'b0;
    open_hdr   = in_byte;
    chdr       = nal_r;
    status_v   = ST_BUSY;
    job        = '0;

    if (in_cmd) begin
      status_v  = ST_READ;
      job.is_read = 1'b1;
      job.rd_ok   = 32'(in_ridx) < 32'(FRAME_BYTES);
      job.ridx    = in_ridx;
    end else begin
      if (pos_r == '0) begin
        kind_nxt = KIND_NONE;
      end

      if (pos_r == POS_MARK) begin
        pmark_nxt = in_byte[7];
      end else if (pos_r == POS_SEQ_HI || pos_r == POS_SEQ_LO) begin
        pseq_nxt = {pseq_r[7:0], in_byte};
      end else if (pos_r >= POS_TS_HI && pos_r <= POS_TS_LO) begin
        pts_nxt = {pts_r[23:0], in_byte};
      end else if (pos_r == POS_HDR_END) begin
        seq_nxt  = pseq_r;
        ts_nxt   = pts_r;
        mark_nxt = pmark_r;
        // a closed frame is released when the next packet header completes
        if (closed_r) begin
          closed_nxt = 1'b0;
          comm_nxt   = '0;
          wr_nxt     = '0;
          ovf_nxt    = 1'b0;
        end
      end else if (pos_r == POS_NAL) begin
        nal_nxt = in_byte;
        if (in_byte[4:0] <= NAL_SINGLE_MAX) begin
          kind_nxt = KIND_SINGLE;
          open_v   = 1'b1;
          open_hdr = in_byte;
        end else if (in_byte[4:0] == NAL_FU_A || in_byte[4:0] == NAL_FU_B) begin
          kind_nxt = KIND_FU_WAIT;
        end else begin
          kind_nxt = KIND_IGNORE;
        end
      end else if (pos_r >= POS_FU_HDR) begin
        if (kind_r == KIND_FU_WAIT) begin
          if (in_byte[7]) begin
            kind_nxt = KIND_FU_START;
            uhdr_nxt = {nal_r[7:5], in_byte[4:0]};
            open_v   = 1'b1;
            open_hdr = {nal_r[7:5], in_byte[4:0]};
          end else if (in_byte[6]) begin
            kind_nxt = KIND_FU_END;
          end else if (!mark_r) begin
            kind_nxt = KIND_FU_MID;
          end else begin
            kind_nxt = KIND_IGNORE;
          end
        end else if (kind_r == KIND_SINGLE || kind_r == KIND_FU_START ||
                     kind_r == KIND_FU_MID || kind_r == KIND_FU_END) begin
          put_v = 1'b1;
        end
      end

      if (open_v) begin
        job.open     = 1'b1;
        job.wr_count = open_n;
        job.wr_addr  = comm_r;
        job.wr_byte  = open_hdr;
        wr_nxt       = comm_r + LEN_W'(open_n);
        ovf_nxt      = open_n != UNIT_OPEN_BYTES;
      end else if (put_v) begin
        job.wr_count = {2'b00, put_ok};
        job.wr_addr  = wr_r;
        job.wr_byte  = in_byte;
        wr_nxt       = wr_r + LEN_W'(put_ok);
        ovf_nxt      = !put_ok;
      end

      if (in_last) begin
        pos_nxt = '0;
        if (pos_r < POS_HDR_END) begin
          status_v = ST_SHORT;
        end else if (kind_nxt == KIND_SINGLE) begin
          commit_v = 1'b1;
          chdr     = nal_nxt;
        end else if (kind_nxt == KIND_FU_END) begin
          commit_v = 1'b1;
          chdr     = uhdr_nxt;
        end else if (kind_nxt == KIND_FU_START || kind_nxt == KIND_FU_MID) begin
          status_v = ST_BUSY;
        end else begin
          status_v = ST_IGNORED;
        end
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + 16'd1;
      end

      if (commit_v) begin
        // a byte written this item keeps the total within the limit
        fail = ovf_nxt || (!open_v && !put_v && wr_gt);
        if (fail) begin
          closed_nxt = 1'b1;
          status_v   = ST_DROPPED;
        end else begin
          comm_nxt = wr_nxt;
          if (chdr == HDR_P_SLICE || chdr == HDR_IDR || chdr == HDR_SEI) begin
            closed_nxt = 1'b1;
            status_v   = ST_READY;
          end else begin
            status_v = ST_STORED;
          end
        end
        wr_nxt  = fail ? comm_r : wr_nxt;
        ovf_nxt = 1'b0;
      end
    end

    job.res.status          = status_v;
    job.res.frame_length    = comm_nxt;
    job.res.sequence_number = seq_nxt;
    job.res.rtp_timestamp   = ts_nxt;
    job.res.nal_type_byte   = (kind_nxt == KIND_SINGLE) ? nal_nxt : uhdr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      kind_r   <= KIND_NONE;
      pmark_r  <= 1'b0;
      pseq_r   <= '0;
      pts_r    <= '0;
      mark_r   <= 1'b0;
      seq_r    <= '0;
      ts_r     <= '0;
      nal_r    <= '0;
      uhdr_r   <= '0;
      comm_r   <= '0;
      wr_r     <= '0;
      ovf_r    <= 1'b0;
      closed_r <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      kind_r   <= kind_nxt;
      pmark_r  <= pmark_nxt;
      pseq_r   <= pseq_nxt;
      pts_r    <= pts_nxt;
      mark_r   <= mark_nxt;
      seq_r    <= seq_nxt;
      ts_r     <= ts_nxt;
      nal_r    <= nal_nxt;
      uhdr_r   <= uhdr_nxt;
      comm_r   <= comm_nxt;
      wr_r     <= wr_nxt;
      ovf_r    <= ovf_nxt;
      closed_r <= closed_nxt;
    end
  end

  // hold the effective limit: the written value capped at the store size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIM_RST;
    end else if (cfg_we) begin
      if (32'(cfg_wdata) > 32'(FRAME_BYTES)) begin
        lim_r <= LEN_W'(FRAME_BYTES);
      end else begin
        lim_r <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/rhd_queue.sv
// Short item queue between the parser and the frame store.
`default_nettype none

module rhd_queue (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  wire rhd_pkg::job_t push_job,
  output logic        pop_valid,
  input  wire logic   pop_ready,
  output rhd_pkg::job_t pop_job
);
  import rhd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push;
  logic          pop;

  assign push_ready = cnt_r != CW'(QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_job    = slot_r[rptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: design/rhd_store.sv
// Frame store: carries out queued writes and reads, holds the result register.
`default_nettype none

module rhd_store #(
  parameter int FRAME_BYTES = 1048576
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       job_valid,
  output logic            job_pop,
  input  wire rhd_pkg::job_t job,
  output logic            res_valid,
  input  wire logic       res_ready,
  output rhd_pkg::result_t res,
  output logic [7:0]      res_read_byte
);
  import rhd_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int XW = (AW > LEN_W) ? AW : LEN_W;

  logic [7:0]    store_r [FRAME_BYTES];
  logic [2:0]    wcnt_r;
  logic [2:0]    wcnt_inc;
  logic          wr_now;
  logic          finish;
  logic          retire;
  logic [XW-1:0] waddr_x;
  logic [XW-1:0] raddr_x;
  logic [7:0]    wdata;
  logic          res_valid_r;
  result_t       res_r;
  logic          rd_hit_r;
  logic [7:0]    rd_byte_r;

  // byte k of a unit opening: 00 00 00 01 then the NAL header
  function automatic logic [7:0] open_byte(input logic [2:0] k, input logic [7:0] hdr);
    logic [7:0] v;
    v = 8'h00;
    if (k == 3'd3) begin
      v = 8'h01;
    end else if (k == 3'd4) begin
      v = hdr;
    end
    return v;
  endfunction

  assign wcnt_inc = wcnt_r + 3'd1;
  assign wr_now   = job_valid && (wcnt_r != job.wr_count);
  assign finish   = job_valid && (wcnt_r == job.wr_count || wcnt_inc == job.wr_count);
  assign retire   = finish && (!res_valid_r || res_ready);
  assign job_pop  = retire;

  assign waddr_x = XW'(job.wr_addr) + XW'(wcnt_r);
  assign raddr_x = XW'(job.ridx);
  assign wdata   = job.open ? open_byte(wcnt_r, job.wr_byte) : job.wr_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (retire) begin
        wcnt_r <= '0;
      end else if (wr_now) begin
        wcnt_r <= wcnt_inc;
      end
      if (retire) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      res_r    <= job.res;
      rd_hit_r <= job.is_read && job.rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_now) begin
      store_r[waddr_x[AW-1:0]] <= wdata;
    end
    if (retire && job.is_read && job.rd_ok) begin
      rd_byte_r <= store_r[raddr_x[AW-1:0]];
    end
  end

  assign res_valid     = res_valid_r;
  assign res           = res_r;
  assign res_read_byte = rd_hit_r ? rd_byte_r : 8'h00;

endmodule

`default_nettype wire

// File: design/rtp_h264_depacketizer.sv
// An accepted item is held in the queue; the store then writes its bytes one at a time and
// registers its result (a unit opening writes up to five bytes: 00 00 00 01 hdr).
// Throughput: one item per cycle while items cause at most one store write and out_tready
// is high; the frame store's single write port sets the rate, a four-entry queue absorbs openings.
// Reset (rst_n, synchronous, active low) clears all parser state and the queue; the
// frame store is not cleared and needs no sweep, so items are taken right after reset.
`default_nettype none

module rtp_h264_depacketizer #(
  parameter int FRAME_BYTES = 1048576
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // data_byte[7:0], read_index[27:8], zero pad
  input  wire logic        in_tuser,   // cmd
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // read_byte[7:0], frame_length[28:8],
                                       // sequence_number[44:29], rtp_timestamp[76:45],
                                       // nal_type_byte[84:77], zero pad
  output logic [2:0]       out_tuser,  // status
  input  wire logic        cfg_we,
  input  wire logic [20:0] cfg_wdata   // max_frame_bytes
);
  import rhd_pkg::*;

  job_t    front_job;
  job_t    head_job;
  logic    q_ready;
  logic    head_valid;
  logic    head_pop;
  result_t res;
  logic [7:0] res_read_byte;

  rhd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_cmd    (in_tuser),
    .in_byte   (in_tdata[7:0]),
    .in_last   (in_tlast),
    .in_ridx   (in_tdata[27:8]),
    .q_ready   (q_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .job       (front_job)
  );

  rhd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (q_ready),
    .push_job   (front_job),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_job    (head_job)
  );

  rhd_store #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (head_valid),
    .job_pop       (head_pop),
    .job           (head_job),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res           (res),
    .res_read_byte (res_read_byte)
  );

  assign in_tready = q_ready;
  assign out_tuser = res.status;
  assign out_tdata = {3'b000, res.nal_type_byte, res.rtp_timestamp, res.sequence_number,
                      res.frame_length, res_read_byte};

endmodule

`default_nettype wire

// File: tb/rhd_tb_pkg.sv
// NAL unit codes shared by the depacketizer testbench files.
`timescale 1ns / 100ps

package rhd_tb_pkg;

  localparam int RTP_HDR_BYTES = 12;

  // NAL header bytes that close a frame
  localparam logic [7:0] HDR_P_SLICE   = 8'h61;
  localparam logic [7:0] HDR_IDR_SLICE = 8'h65;
  localparam logic [7:0] HDR_SEI       = 8'h06;

  // NAL unit types carried in the low five bits of the NAL byte
  localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
  localparam logic [4:0] NAL_STAP_A     = 5'd24;
  localparam logic [4:0] NAL_MTAP24     = 5'd27;
  localparam logic [4:0] NAL_FU_A       = 5'd28;
  localparam logic [4:0] NAL_FU_B       = 5'd29;
  localparam logic [4:0] NAL_RSVD_LO    = 5'd30;
  localparam logic [4:0] NAL_RSVD_HI    = 5'd31;

endpackage

// File: tb/rhd_checker.sv
// Depacketizer checker: predicts every result from accepted items and compares in order.
`timescale 1ns / 100ps

module rhd_checker #(
  parameter int FRAME_BYTES = 1048576
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [87:0] out_tdata,
  input  wire logic [2:0]  out_tuser,
  input  wire logic        cfg_we,
  input  wire logic [20:0] cfg_wdata,
  output int               failures,
  output int               pending,
  output int unsigned      written_bytes
);

  import rhd_pkg::*;
  import rhd_tb_pkg::*;

  // byte positions within the RTP packet
  localparam logic [15:0] POS_MARKER   = 16'd1;
  localparam logic [15:0] POS_SEQ_HI   = 16'd2;
  localparam logic [15:0] POS_SEQ_LO   = 16'd3;
  localparam logic [15:0] POS_TS_FIRST = 16'd4;
  localparam logic [15:0] POS_TS_LAST  = 16'd7;
  localparam logic [15:0] POS_TAKEOVER = 16'd11;
  localparam logic [15:0] POS_NAL      = 16'd12;
  localparam logic [15:0] POS_FU_HDR   = 16'd13;

  typedef enum logic [2:0] {
    PK_NONE     = 3'd0,
    PK_SINGLE   = 3'd1,
    PK_IGNORE   = 3'd2,
    PK_FU_WAIT  = 3'd4,
    PK_FU_START = 3'd5,
    PK_FU_MID   = 3'd6,
    PK_FU_END   = 3'd7
  } pkt_kind_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic [20:0] frame_length;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  nal;
  } depkt_result_t;

  depkt_result_t due_results[$];

  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [20:0] max_bytes;
  logic [15:0] byte_pos;
  logic [20:0] committed;
  logic [20:0] unit_len;
  logic        frame_closed;
  logic        unit_ovf;
  pkt_kind_t   kind;
  logic        marker;
  logic [7:0]  ind_byte;
  logic [7:0]  hdr_byte;
  logic [15:0] latest_seq;
  logic [31:0] latest_ts;
  logic [15:0] pend_seq;
  logic [31:0] pend_ts;
  logic        pend_marker;

  function automatic logic [21:0] frame_cap();
    return 22'((max_bytes > FRAME_BYTES) ? FRAME_BYTES : max_bytes);
  endfunction

  task automatic store_unit_byte(input logic [7:0] b);
    logic [21:0] addr;
    addr = committed + unit_len;
    if (unit_ovf || addr >= frame_cap()) begin
      unit_ovf = 1'b1;
    end else begin
      frame_mem[addr] = b;
      unit_len = unit_len + 1'b1;
      if (addr + 1 > written_bytes) written_bytes = addr + 1;
    end
  endtask

  task automatic open_unit(input logic [7:0] hdr);
    unit_len = '0;
    unit_ovf = 1'b0;
    store_unit_byte(8'h00);
    store_unit_byte(8'h00);
    store_unit_byte(8'h00);
    store_unit_byte(8'h01);
    store_unit_byte(hdr);
  endtask

  task automatic commit_unit(input logic [7:0] hdr, output logic [2:0] st);
    logic [21:0] total;
    total = committed + unit_len;
    if (unit_ovf || total > frame_cap()) begin
      frame_closed = 1'b1;
      st = ST_DROPPED;
    end else begin
      committed = total[20:0];
      if (hdr == HDR_P_SLICE || hdr == HDR_IDR_SLICE || hdr == HDR_SEI) begin
        frame_closed = 1'b1;
        st = ST_READY;
      end else begin
        st = ST_STORED;
      end
    end
    unit_len = '0;
    unit_ovf = 1'b0;
  endtask

  task automatic depacketize_item(input logic cmd, input logic [7:0] b, input logic last,
                                  input logic [19:0] ridx);
    depkt_result_t r;
    logic [15:0]   p;
    logic [2:0]    st;
    st = ST_BUSY;
    r = '0;
    p = byte_pos;
    if (cmd) begin
      st = ST_READ;
      if (ridx < FRAME_BYTES) r.read_byte = frame_mem[ridx];
    end else begin
      if (p == 0) kind = PK_NONE;
      if (p == POS_MARKER) begin
        pend_marker = b[7];
      end else if (p == POS_SEQ_HI || p == POS_SEQ_LO) begin
        pend_seq = {pend_seq[7:0], b};
      end else if (p >= POS_TS_FIRST && p <= POS_TS_LAST) begin
        pend_ts = {pend_ts[23:0], b};
      end else if (p == POS_TAKEOVER) begin
        latest_seq = pend_seq;
        latest_ts = pend_ts;
        marker = pend_marker;
        // a closed frame starts over with the next packet
        if (frame_closed) begin
          frame_closed = 1'b0;
          committed = '0;
          unit_len = '0;
          unit_ovf = 1'b0;
        end
      end else if (p == POS_NAL) begin
        ind_byte = b;
        if (b[4:0] <= NAL_SINGLE_MAX) begin
          kind = PK_SINGLE;
          open_unit(b);
        end else if (b[4:0] == NAL_FU_A || b[4:0] == NAL_FU_B) begin
          kind = PK_FU_WAIT;
        end else begin
          kind = PK_IGNORE;
        end
      end else if (p >= POS_FU_HDR) begin
        if (kind == PK_FU_WAIT) begin
          if (b[7]) begin
            kind = PK_FU_START;
            hdr_byte = {ind_byte[7:5], b[4:0]};
            open_unit(hdr_byte);
          end else if (b[6]) begin
            kind = PK_FU_END;
          end else if (!marker) begin
            kind = PK_FU_MID;
          end else begin
            kind = PK_IGNORE;
          end
        end else if (kind == PK_SINGLE || kind == PK_FU_START || kind == PK_FU_MID ||
                     kind == PK_FU_END) begin
          store_unit_byte(b);
        end
      end

      if (last) begin
        if (p < POS_TAKEOVER) st = ST_SHORT;
        else if (kind == PK_SINGLE) commit_unit(ind_byte, st);
        else if (kind == PK_FU_END) commit_unit(hdr_byte, st);
        else if (kind == PK_FU_START || kind == PK_FU_MID) st = ST_BUSY;
        else st = ST_IGNORED;
        byte_pos = '0;
      end else if (byte_pos != 16'hFFFF) begin
        byte_pos = byte_pos + 1'b1;
      end
    end

    r.status = st;
    r.frame_length = committed;
    r.seq = latest_seq;
    r.ts = latest_ts;
    r.nal = (kind == PK_SINGLE) ? ind_byte : hdr_byte;
    due_results.push_back(r);
  endtask

  task automatic check_result();
    depkt_result_t got;
    depkt_result_t want;
    got.status = out_tuser;
    got.read_byte = out_tdata[7:0];
    got.frame_length = out_tdata[28:8];
    got.seq = out_tdata[44:29];
    got.ts = out_tdata[76:45];
    got.nal = out_tdata[84:77];
    if (due_results.size() == 0) begin
      $display("%0t: result with nothing due: status %0d read %h length %0d nal %h",
               $time, got.status, got.read_byte, got.frame_length, got.nal);
      failures++;
    end else begin
      want = due_results.pop_front();
      if (got !== want) begin
        $display("%0t: exp/act st %0d/%0d rd %h/%h len %0d/%0d seq %h/%h ts %h/%h nal %h/%h",
                 $time, want.status, got.status, want.read_byte, got.read_byte,
                 want.frame_length, got.frame_length, want.seq, got.seq,
                 want.ts, got.ts, want.nal, got.nal);
        failures++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      max_bytes = 21'h100000;
      byte_pos = '0;
      committed = '0;
      unit_len = '0;
      frame_closed = 1'b0;
      unit_ovf = 1'b0;
      kind = PK_NONE;
      marker = 1'b0;
      ind_byte = '0;
      hdr_byte = '0;
      latest_seq = '0;
      latest_ts = '0;
      pend_seq = '0;
      pend_ts = '0;
      pend_marker = 1'b0;
      written_bytes = 0;
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_we) max_bytes = cfg_wdata;
      if (in_tvalid && in_tready)
        depacketize_item(in_tuser, in_tdata[7:0], in_tlast, in_tdata[27:8]);
    end
    pending = due_results.size();
  end

endmodule

// File: tb/tb_top.sv
// Testbench top: drives RTP packets, frame reads and limit writes into the depacketizer.
`timescale 1ns / 100ps

module tb_top;

  import rhd_tb_pkg::*;

  localparam int FRAME_BYTES     = 1048576;
  localparam int CYCLE_LIMIT     = 3000000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 220;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // data_byte[7:0], read_index[27:8], zero pad
  logic        in_tuser;   // cmd
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;  // read_byte[7:0], frame_length[28:8], sequence_number[44:29],
                           // rtp_timestamp[76:45], nal_type_byte[84:77], zero pad
  logic [2:0]  out_tuser;  // status
  logic        cfg_we;
  logic [20:0] cfg_wdata;  // max_frame_bytes

  int          failures;
  int          pending;
  int unsigned written_bytes;

  int          send_idle = 0;
  int          recv_idle = 0;
  int          read_mix = 0;
  int          items_sent = 0;
  bit          hold_off = 1'b0;
  logic [7:0]  pkt[$];

  rtp_h264_depacketizer #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rhd_checker #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .failures     (failures),
    .pending      (pending),
    .written_bytes(written_bytes)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_tready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("rtp_h264_depacketizer: mismatch");
    $finish;
  end

  // offer one item and hold it until accepted; returns at a falling edge
  task automatic send_item(input logic cmd, input logic [7:0] b, input logic last,
                           input logic [19:0] idx);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tlast = last;
    in_tdata = {4'd0, idx, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_read(input logic [19:0] idx);
    send_item(1'b1, 8'($urandom()), 1'($urandom_range(0, 1)), idx);
  endtask

  // read only bytes that some unit has already written
  task automatic random_read();
    if (written_bytes == 0) return;
    case ($urandom_range(0, 3))
      0: send_read(20'd0);
      1: send_read(20'(written_bytes - 1));
      default: send_read(20'($urandom_range(0, written_bytes - 1)));
    endcase
  endtask

  task automatic open_packet(input logic marker);
    pkt.delete();
    repeat (RTP_HDR_BYTES) pkt.push_back(8'($urandom_range(0, 255)));
    pkt[1][7] = marker;
  endtask

  task automatic add_payload(input int n);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_packet();
    foreach (pkt[i]) begin
      if ($urandom_range(0, 99) < read_mix) random_read();
      send_item(1'b0, pkt[i], i == pkt.size() - 1, 20'($urandom()));
    end
  endtask

  function automatic logic [7:0] nal_header();
    logic [2:0] nri;
    logic [4:0] t;
    nri = 3'($urandom_range(0, 7));
    t = 5'($urandom_range(0, NAL_SINGLE_MAX));
    case ($urandom_range(0, 5))
      0: return HDR_P_SLICE;
      1: return HDR_IDR_SLICE;
      2: return HDR_SEI;
      default: return {nri, t};
    endcase
  endfunction

  task automatic single_packet(input logic [7:0] hdr, input int n);
    open_packet(1'($urandom_range(0, 1)));
    pkt.push_back(hdr);
    add_payload(n);
    send_packet();
  endtask

  task automatic fu_packet(input logic [4:0] ind_type, input logic [2:0] nri, input logic s,
                           input logic e, input logic [4:0] unit_type, input logic marker,
                           input int n);
    logic rsvd;
    rsvd = 1'($urandom_range(0, 1));
    open_packet(marker);
    pkt.push_back({nri, ind_type});
    pkt.push_back({s, e, rsvd, unit_type});
    add_payload(n);
    send_packet();
  endtask

  // start fragment, middles with marker clear, end fragment
  task automatic fu_unit(input int mids);
    logic [7:0] hdr;
    logic [4:0] ind_type;
    int         k;
    hdr = nal_header();
    ind_type = $urandom_range(0, 1) ? NAL_FU_A : NAL_FU_B;
    fu_packet(ind_type, hdr[7:5], 1'b1, 1'($urandom_range(0, 1)), hdr[4:0],
              1'($urandom_range(0, 1)), $urandom_range(0, 15));
    for (k = 0; k < mids; k++)
      fu_packet(ind_type, 3'($urandom()), 1'b0, 1'b0, 5'($urandom()), 1'b0,
                $urandom_range(0, 15));
    fu_packet(ind_type, 3'($urandom()), 1'b0, 1'b1, 5'($urandom()),
              1'($urandom_range(0, 1)), $urandom_range(0, 15));
  endtask

  task automatic noise_packet();
    logic [2:0] nri;
    logic [4:0] fu_type;
    nri = 3'($urandom_range(0, 7));
    fu_type = $urandom_range(0, 1) ? NAL_FU_A : NAL_FU_B;
    case ($urandom_range(0, 8))
      0: begin
        open_packet(1'($urandom_range(0, 1)));
        repeat (RTP_HDR_BYTES - $urandom_range(1, 11)) void'(pkt.pop_back());
        send_packet();
      end
      1: begin
        open_packet(1'($urandom_range(0, 1)));
        send_packet();
      end
      2: begin
        open_packet(1'($urandom_range(0, 1)));
        pkt.push_back({nri, fu_type});
        send_packet();
      end
      3: begin
        open_packet(1'($urandom_range(0, 1)));
        pkt.push_back({nri, 5'($urandom_range(NAL_STAP_A, NAL_MTAP24))});
        add_payload($urandom_range(0, 10));
        send_packet();
      end
      4: begin
        open_packet(1'($urandom_range(0, 1)));
        pkt.push_back({nri, 5'($urandom_range(NAL_RSVD_LO, NAL_RSVD_HI))});
        add_payload($urandom_range(0, 10));
        send_packet();
      end
      5: fu_packet(fu_type, nri, 1'b0, 1'b0, 5'($urandom()), 1'b0, $urandom_range(0, 12));
      6: fu_packet(fu_type, nri, 1'b0, 1'b0, 5'($urandom()), 1'b1, $urandom_range(0, 12));
      7: fu_packet(fu_type, nri, 1'b0, 1'b1, 5'($urandom()), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 12));
      default: fu_packet(fu_type, nri, 1'b1, 1'($urandom_range(0, 1)), 5'($urandom()),
                         1'($urandom_range(0, 1)), $urandom_range(0, 12));
    endcase
  endtask

  task automatic random_traffic(input int target);
    int first;
    int pick;
    first = items_sent;
    while (items_sent - first < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) single_packet(nal_header(), $urandom_range(0, 20));
      else if (pick < 70) fu_unit($urandom_range(0, 2));
      else noise_packet();
    end
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(input logic [20:0] value);
    settle();
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // too short, cut before and at the last header byte
    open_packet(1'b0);
    repeat (7) void'(pkt.pop_back());
    send_packet();
    open_packet(1'b1);
    void'(pkt.pop_back());
    send_packet();
    // header only, no NAL byte
    open_packet(1'b0);
    send_packet();
    // single NAL with payload extremes, then read it back
    open_packet(1'b0);
    pkt.push_back(8'h01);
    pkt.push_back(8'h00);
    pkt.push_back(8'hFF);
    send_packet();
    send_read(20'd0);
    send_read(20'(written_bytes - 1));
    single_packet(HDR_IDR_SLICE, 0);
    single_packet({3'b111, NAL_SINGLE_MAX}, 1);
    // start, middle, end building a P slice header
    fu_packet(NAL_FU_A, 3'b011, 1'b1, 1'b0, 5'd1, 1'b0, 2);
    fu_packet(NAL_FU_A, 3'b100, 1'b0, 1'b0, 5'd0, 1'b0, 2);
    fu_packet(NAL_FU_A, 3'b000, 1'b0, 1'b1, 5'd31, 1'b1, 1);
    // fragment header missing
    open_packet(1'b0);
    pkt.push_back({3'b000, NAL_FU_B});
    send_packet();
    // aggregation and reserved types
    open_packet(1'b1);
    pkt.push_back({3'b111, NAL_STAP_A});
    add_payload(2);
    send_packet();
    open_packet(1'b0);
    pkt.push_back({3'b111, NAL_RSVD_HI});
    add_payload(1);
    send_packet();
    // middle and end with no start, middle under marker
    fu_packet(NAL_FU_B, 3'b010, 1'b0, 1'b0, 5'd5, 1'b0, 3);
    fu_packet(NAL_FU_B, 3'b010, 1'b0, 1'b1, 5'd5, 1'b1, 1);
    fu_packet(NAL_FU_A, 3'b001, 1'b0, 1'b0, 5'd7, 1'b1, 2);
    // start and end bits together count as start; abandon it with a single NAL
    fu_packet(NAL_FU_B, 3'b000, 1'b1, 1'b1, 5'd6, 1'b1, 1);
    single_packet(HDR_SEI, 0);

    set_limit(21'd1);
    single_packet(nal_header(), 3);
    fu_unit(1);
    set_limit(21'd0);
    single_packet(nal_header(), 2);
    set_limit(21'h1FFFFF);
    single_packet(nal_header(), 2);
    fu_unit(0);

    set_limit(21'($urandom_range(40, 400)));
    send_idle = 9;
    recv_idle = 59;
    read_mix = 8;
    // stall the result side long enough to back up the input
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    random_traffic(PHASE_ITEMS);

    set_limit(21'($urandom_range(16, 120)));
    send_idle = 59;
    recv_idle = 9;
    random_traffic(PHASE_ITEMS / 2);
    drain();
    random_traffic(PHASE_ITEMS / 2);

    set_limit(21'h100000);
    send_idle = 0;
    recv_idle = 0;
    random_traffic(PHASE_ITEMS);
    repeat (24) random_read();

    settle();
    if (failures == 0) begin
      $display("rtp_h264_depacketizer: match");
    end else begin
      $display("rtp_h264_depacketizer: mismatch");
    end
    $finish;
  end

endmodule

// File: rtp_h264_depacketizer.f
design/rhd_pkg.sv
design/rhd_front.sv
design/rhd_queue.sv
design/rhd_store.sv
design/rtp_h264_depacketizer.sv
tb/rhd_tb_pkg.sv
tb/rhd_checker.sv
tb/tb_top.sv
